// File: rtl/mexp_pkg.sv
// shared widths, types and unit request/status structs for modular exponentiation
package mexp_pkg;

	localparam int unsigned OPERAND_WIDTH = 32;
	localparam int unsigned PROD_WIDTH    = 2 * OPERAND_WIDTH;
	localparam int unsigned CNT_WIDTH     = $clog2(PROD_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0] operand_t;
	typedef logic [PROD_WIDTH-1:0]    product_t;

	// request to the shared modular multiply unit
	typedef struct packed {
		logic     start;
		operand_t a;
		operand_t b;
		operand_t m;
	} mm_req_t;

	// status back from the shared modular multiply unit
	typedef struct packed {
		logic     busy;
		logic     done;
		operand_t rem;
	} mm_stat_t;

endpackage

// File: rtl/mexp_ifs.sv
// valid/ready channel interfaces for operand and result transactions

interface mexp_in_if;
	logic                valid;
	logic                ready;
	mexp_pkg::operand_t  base_value;
	mexp_pkg::operand_t  exponent_value;
	mexp_pkg::operand_t  modulus_value;

	modport source (output valid, output base_value, output exponent_value,
		output modulus_value, input ready);
	modport sink (input valid, input base_value, input exponent_value,
		input modulus_value, output ready);
endinterface

interface mexp_out_if;
	logic                valid;
	logic                ready;
	mexp_pkg::operand_t  power_result;
	logic                zero_modulus_error;

	modport source (output valid, output power_result, output zero_modulus_error,
		input ready);
	modport sink (input valid, input power_result, input zero_modulus_error,
		output ready);
endinterface

// File: rtl/mexp_mulmod.sv
// shared modular multiply unit: one full product, then bit-serial restoring remainder
module mexp_mulmod (
	input  logic               clk,
	input  logic               arst_n,
	input  mexp_pkg::mm_req_t  req,
	output mexp_pkg::mm_stat_t stat
);

	localparam logic [1:0] MM_IDLE = 2'd0;
	localparam logic [1:0] MM_MUL  = 2'd1;
	localparam logic [1:0] MM_RED  = 2'd2;

	localparam int unsigned W = mexp_pkg::OPERAND_WIDTH;
	localparam int unsigned P = mexp_pkg::PROD_WIDTH;

	logic [1:0]                          state_q;
	logic                                done_q;
	logic [mexp_pkg::CNT_WIDTH-1:0]      cnt_q;
	mexp_pkg::operand_t                  a_q;
	mexp_pkg::operand_t                  b_q;
	mexp_pkg::operand_t                  m_q;
	mexp_pkg::product_t                  prod_q;
	mexp_pkg::operand_t                  rem_q;

	mexp_pkg::product_t                  mul_full;
	logic [W:0]                          shifted;
	logic [W:0]                          diff;
	mexp_pkg::operand_t                  rem_next;

	// full double-width product
	assign mul_full = P'(a_q) * P'(b_q);

	// one restoring remainder step: bring in next product bit, subtract if it fits
	assign shifted  = {rem_q, prod_q[P-1]};
	assign diff     = shifted - {1'b0, m_q};
	assign rem_next = diff[W] ? shifted[W-1:0] : diff[W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MM_IDLE: begin
					if (req.start) begin
						state_q <= MM_MUL;
					end
				end
				MM_MUL: begin
					cnt_q   <= mexp_pkg::CNT_WIDTH'(P - 1);
					state_q <= MM_RED;
				end
				MM_RED: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= MM_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= MM_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			MM_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
					m_q <= req.m;
				end
			end
			MM_MUL: begin
				prod_q <= mul_full;
				rem_q  <= '0;
			end
			MM_RED: begin
				rem_q  <= rem_next;
				prod_q <= {prod_q[P-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != MM_IDLE);
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

// File: rtl/modular_exponentiation_top.sv
// modular exponentiation top: square-and-multiply sequencer around the shared mulmod unit
// one modular product: launch, multiply, 64 remainder steps, done
// an item reduces the base, then per exponent bit multiplies it into the accumulator
//   if the bit is set and squares the base; the result is registered from the final state
// a zero modulus goes straight to the final state; one item in flight, output stalls hold that state
// a new transaction is accepted only once the sequencer returns to idle
// reset: arst_n asynchronously clears sequencer, unit state and the output valid flag
module modular_exponentiation_top (
	input  logic  clk,
	input  logic  arst_n,
	mexp_in_if.sink    operands,
	mexp_out_if.source results
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BASE  = 4'd1;
	localparam logic [3:0] ST_WBASE = 4'd2;
	localparam logic [3:0] ST_CHECK = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_WACC  = 4'd5;
	localparam logic [3:0] ST_SQ    = 4'd6;
	localparam logic [3:0] ST_WSQ   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0]          state_q;
	logic                out_valid_q;
	mexp_pkg::operand_t  base_q;
	mexp_pkg::operand_t  expo_q;
	mexp_pkg::operand_t  mod_q;
	mexp_pkg::operand_t  acc_q;
	logic                err_q;
	mexp_pkg::operand_t  out_result_q;
	logic                out_err_q;

	logic                accept;
	logic                out_free;
	mexp_pkg::mm_req_t   mm_req;
	mexp_pkg::mm_stat_t  mm_stat;

	assign operands.ready = (state_q == ST_IDLE);
	assign accept         = operands.valid && operands.ready;
	assign out_free       = !out_valid_q || results.ready;

	// operand select for the shared unit
	always_comb begin
		mm_req.start = (state_q == ST_BASE) || (state_q == ST_ACC) || (state_q == ST_SQ);
		mm_req.a     = (state_q == ST_ACC) ? acc_q : base_q;
		mm_req.b     = (state_q == ST_BASE) ? mexp_pkg::operand_t'(1) : base_q;
		mm_req.m     = mod_q;
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.stat   (mm_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (operands.modulus_value == '0) ? ST_FIN : ST_BASE;
					end
				end
				ST_BASE: state_q <= ST_WBASE;
				ST_WBASE: begin
					if (mm_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (expo_q == '0) begin
						state_q <= ST_FIN;
					end else if (expo_q[0]) begin
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_ACC: state_q <= ST_WACC;
				ST_WACC: begin
					if (mm_stat.done) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_WSQ;
				ST_WSQ: begin
					if (mm_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers and output register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q <= operands.base_value;
					expo_q <= operands.exponent_value;
					mod_q  <= operands.modulus_value;
					err_q  <= (operands.modulus_value == '0);
					acc_q  <= (operands.modulus_value == '0) ? '0 : mexp_pkg::operand_t'(1);
				end
			end
			ST_WBASE: begin
				if (mm_stat.done) begin
					base_q <= mm_stat.rem;
				end
			end
			ST_WACC: begin
				if (mm_stat.done) begin
					acc_q <= mm_stat.rem;
				end
			end
			ST_WSQ: begin
				if (mm_stat.done) begin
					base_q <= mm_stat.rem;
					expo_q <= {1'b0, expo_q[mexp_pkg::OPERAND_WIDTH-1:1]};
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_result_q <= acc_q;
					out_err_q    <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign results.valid              = out_valid_q;
	assign results.power_result       = out_result_q;
	assign results.zero_modulus_error = out_err_q;

	// unit is never started while still working
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_req.start |-> !mm_stat.busy)
		else $error("mulmod started while busy");

	// unit completion only seen while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_stat.done |-> (state_q == ST_WBASE || state_q == ST_WACC || state_q == ST_WSQ))
		else $error("mulmod done outside a wait state");

	// block stops taking transactions right after one is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !operands.ready)
		else $error("accepted a second transaction while busy");

	// a flagged zero modulus always carries a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.zero_modulus_error) |-> (results.power_result == '0))
		else $error("zero modulus result not zero");

endmodule
